// ----- rtl/core/pending_size_match_table_macros.svh -----
// assertion macros for the pending size match table
// used by the top level; expects clk and rst_n in scope
`ifndef PENDING_SIZE_MATCH_TABLE_MACROS_SVH
`define PENDING_SIZE_MATCH_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pst_pkg.sv -----
// shared types and codes of the pending size match table
// no dependencies
`default_nettype none

package pst_pkg;

  localparam int HANDLE_W = 64;
  localparam int SIZE_W   = 64;
  localparam int MASK_W   = 32;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 3;
  localparam int COUNT_W  = 6;

  localparam logic [REQ_W-1:0] REQ_RECORD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLAIM  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FORGET = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD   = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FALLBACK = 3'd4;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [MASK_W-1:0]   mask;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/pst_channels.sv -----
// request and result channel interfaces of the pending size match table
// depends on pst_pkg for field widths
`default_nettype none

interface pst_req_if;
  logic                         valid;
  logic                         ready;
  logic [pst_pkg::REQ_W-1:0]    req_type;
  logic [pst_pkg::HANDLE_W-1:0] image_handle;
  logic [pst_pkg::SIZE_W-1:0]   req_size;
  logic [pst_pkg::MASK_W-1:0]   type_mask;

  modport source (output valid, req_type, image_handle, req_size, type_mask, input ready);
  modport sink   (input valid, req_type, image_handle, req_size, type_mask, output ready);
endinterface

interface pst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pst_pkg::STAT_W-1:0]   status;
  logic [pst_pkg::HANDLE_W-1:0] claimed_handle;
  logic [pst_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, claimed_handle, entry_count, input ready);
  modport sink   (input valid, status, claimed_handle, entry_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pst_entry_mem.sv -----
// entry memory: one write port, one read port with registered read data
// depends on pst_pkg for the entry type
`default_nettype none

module pst_entry_mem #(
  parameter int DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output pst_pkg::entry_t                 rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire pst_pkg::entry_t            wr_data
);

  pst_pkg::entry_t mem [DEPTH];
  pst_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/pst_cmp_unit.sv -----
// shared compare unit: matches a key against the handle or size of an entry
// and builds the updated entry for a record hit; depends on pst_pkg
`default_nettype none

module pst_cmp_unit (
  input  wire logic                        by_size,
  input  wire logic [pst_pkg::SIZE_W-1:0]  key,
  input  wire pst_pkg::entry_t             entry,
  input  wire logic [pst_pkg::SIZE_W-1:0]  upd_size,
  input  wire logic [pst_pkg::MASK_W-1:0]  upd_mask,
  output logic                             hit,
  output pst_pkg::entry_t                  merged
);

  logic [pst_pkg::SIZE_W-1:0] field;

  assign field = by_size ? entry.size : entry.handle;
  assign hit   = (field == key);

  // zero fields leave the stored value alone
  always_comb begin
    merged = entry;
    if (upd_size != '0) begin
      merged.size = upd_size;
    end
    if (upd_mask != '0) begin
      merged.mask = upd_mask;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pending_size_match_table.sv -----
// Pending size match table: a compacted list of up to DEPTH (handle, size, mask) entries,
// oldest first. One transaction is handled at a time: in_ch.ready is high only while the
// sequencer is idle. The entry memory is walked one entry per cycle through its single
// registered read port and a shared compare unit. A claim or forget that removes an
// entry also moves the tail down one entry per cycle. A finished result waits in the
// sequencer while the output register is still busy. The result sits in an output
// register, so the next transaction is taken while a result is still waiting. No memory
// clearing after reset is needed.
`default_nettype none

module pending_size_match_table #(
  parameter int DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pst_req_if.sink    in_ch,
  pst_rsp_if.source  out_ch
);

  `include "pending_size_match_table_macros.svh"

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > pst_pkg::COUNT_W) ? CNT_W : pst_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               fill_r, fill_nxt;
  logic                           pv_r, pv_nxt;
  logic [AW-1:0]                  pidx_r, pidx_nxt;
  logic [CNT_W-1:0]               ptr_r, ptr_nxt;
  logic [CNT_W-1:0]               rem_r, rem_nxt;
  logic [pst_pkg::REQ_W-1:0]      op_r, op_nxt;
  logic [pst_pkg::HANDLE_W-1:0]   key_h_r, key_h_nxt;
  logic [pst_pkg::SIZE_W-1:0]     key_sz_r, key_sz_nxt;
  logic [pst_pkg::MASK_W-1:0]     key_m_r, key_m_nxt;
  logic [pst_pkg::HANDLE_W-1:0]   newest_r, newest_nxt;
  logic [pst_pkg::HANDLE_W-1:0]   got_r, got_nxt;
  logic [pst_pkg::STAT_W-1:0]     st_r, st_nxt;
  logic                           out_vld_r, out_vld_nxt;
  logic [pst_pkg::STAT_W-1:0]     out_st_r, out_st_nxt;
  logic [pst_pkg::HANDLE_W-1:0]   out_got_r, out_got_nxt;
  logic [pst_pkg::COUNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic                           in_fire;
  logic [CNT_W-1:0]               fill_m1;
  logic [CNT_W-1:0]               ptr_m1;
  logic [CNT_W-1:0]               pidx_ext;
  logic [EXT_W-1:0]               cnt_ext;
  logic                           is_claim;

  logic                           mem_rd_en;
  logic [AW-1:0]                  mem_rd_addr;
  pst_pkg::entry_t                mem_rd_data;
  logic                           mem_we;
  logic [AW-1:0]                  mem_wr_addr;
  pst_pkg::entry_t                mem_wr_data;

  logic                           hit;
  pst_pkg::entry_t                merged;

  pst_entry_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  pst_cmp_unit u_cmp (
    .by_size  (is_claim),
    .key      (is_claim ? key_sz_r : key_h_r),
    .entry    (mem_rd_data),
    .upd_size (key_sz_r),
    .upd_mask (key_m_r),
    .hit      (hit),
    .merged   (merged)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign is_claim = (op_r == pst_pkg::REQ_CLAIM);
  assign fill_m1  = fill_r - CNT_W'(1);
  assign ptr_m1   = ptr_r - CNT_W'(1);
  assign pidx_ext = CNT_W'(pidx_r);
  assign cnt_ext  = EXT_W'(fill_r);

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.claimed_handle = out_got_r;
  assign out_ch.entry_count    = out_cnt_r;

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    pv_nxt      = 1'b0;
    pidx_nxt    = pidx_r;
    ptr_nxt     = ptr_r;
    rem_nxt     = rem_r;
    op_nxt      = op_r;
    key_h_nxt   = key_h_r;
    key_sz_nxt  = key_sz_r;
    key_m_nxt   = key_m_r;
    newest_nxt  = newest_r;
    got_nxt     = got_r;
    st_nxt      = st_r;
    out_vld_nxt = out_vld_r;
    out_st_nxt  = out_st_r;
    out_got_nxt = out_got_r;
    out_cnt_nxt = out_cnt_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ptr_r[AW-1:0];
    mem_we      = 1'b0;
    mem_wr_addr = pidx_r;
    mem_wr_data = mem_rd_data;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_ch.req_type;
          key_h_nxt  = in_ch.image_handle;
          key_sz_nxt = in_ch.req_size;
          key_m_nxt  = in_ch.type_mask;
          got_nxt    = '0;
          rem_nxt    = fill_r;
          ptr_nxt    = (in_ch.req_type == pst_pkg::REQ_CLAIM) ? fill_m1 : '0;
          if (in_ch.req_type == pst_pkg::REQ_RECORD && in_ch.image_handle == '0) begin
            st_nxt    = pst_pkg::ST_NULL;
            state_nxt = S_FINISH;
          end else if (in_ch.req_type == pst_pkg::REQ_RSVD) begin
            st_nxt    = pst_pkg::ST_DONE;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle, compare it the cycle after
        if (rem_r != '0) begin
          mem_rd_en = 1'b1;
          pv_nxt    = 1'b1;
          pidx_nxt  = ptr_r[AW-1:0];
          rem_nxt   = rem_r - CNT_W'(1);
          ptr_nxt   = is_claim ? ptr_m1 : ptr_r + CNT_W'(1);
        end
        if (pv_r && pidx_ext == fill_m1) begin
          newest_nxt = mem_rd_data.handle;
        end
        if (pv_r && hit) begin
          pv_nxt = 1'b0;
          st_nxt = pst_pkg::ST_DONE;
          if (op_r == pst_pkg::REQ_RECORD) begin
            mem_we      = 1'b1;
            mem_wr_addr = pidx_r;
            mem_wr_data = merged;
            state_nxt   = S_FINISH;
          end else begin
            got_nxt = is_claim ? mem_rd_data.handle : '0;
            if (pidx_ext == fill_m1) begin
              fill_nxt  = fill_m1;
              state_nxt = S_FINISH;
            end else begin
              // close the gap: move entries above the hit down by one
              ptr_nxt   = pidx_ext + CNT_W'(1);
              rem_nxt   = fill_m1 - pidx_ext;
              state_nxt = S_SHIFT;
            end
          end
        end else if (rem_r == '0) begin
          pv_nxt    = 1'b0;
          state_nxt = S_FINISH;
          if (op_r == pst_pkg::REQ_RECORD) begin
            if (fill_r == CNT_W'(DEPTH)) begin
              st_nxt = pst_pkg::ST_FULL;
            end else begin
              mem_we      = 1'b1;
              mem_wr_addr = fill_r[AW-1:0];
              mem_wr_data = '{handle: key_h_r, size: key_sz_r, mask: key_m_r};
              fill_nxt    = fill_r + CNT_W'(1);
              st_nxt      = pst_pkg::ST_DONE;
            end
          end else if (is_claim && fill_r != '0) begin
            fill_nxt = fill_m1;
            got_nxt  = (pv_r && pidx_ext == fill_m1) ? mem_rd_data.handle : newest_r;
            st_nxt   = pst_pkg::ST_FALLBACK;
          end else begin
            st_nxt = pst_pkg::ST_NOTFOUND;
          end
        end
      end

      S_SHIFT: begin
        if (rem_r != '0) begin
          mem_rd_en = 1'b1;
          pv_nxt    = 1'b1;
          pidx_nxt  = ptr_m1[AW-1:0];
          rem_nxt   = rem_r - CNT_W'(1);
          ptr_nxt   = ptr_r + CNT_W'(1);
        end
        if (pv_r) begin
          mem_we      = 1'b1;
          mem_wr_addr = pidx_r;
          mem_wr_data = mem_rd_data;
          if (rem_r == '0) begin
            fill_nxt  = fill_m1;
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_st_nxt  = st_r;
          out_got_nxt = got_r;
          out_cnt_nxt = cnt_ext[pst_pkg::COUNT_W-1:0];
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      pv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      pv_r      <= pv_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r    <= pidx_nxt;
    ptr_r     <= ptr_nxt;
    rem_r     <= rem_nxt;
    op_r      <= op_nxt;
    key_h_r   <= key_h_nxt;
    key_sz_r  <= key_sz_nxt;
    key_m_r   <= key_m_nxt;
    newest_r  <= newest_nxt;
    got_r     <= got_nxt;
    st_r      <= st_nxt;
    out_st_r  <= out_st_nxt;
    out_got_r <= out_got_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  `PST_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CNT_W'(DEPTH), "fill count above depth")
  `PST_ASSERT_IMP(a_scan_in_range, state_r == S_SCAN && pv_r, pidx_ext < fill_r, "compare beyond fill")
  `PST_ASSERT_IMP(a_shift_in_range, state_r == S_SHIFT && pv_r, pidx_ext + CNT_W'(1) < fill_r, "shift write beyond tail")
  `PST_ASSERT_NXT(a_busy_after_accept, in_fire, state_r != S_IDLE, "idle right after accepting a transaction")

endmodule

`default_nettype wire

// ----- tb/pst_scoreboard.sv -----
// checker for the pending size match table: watches both channels, keeps its own
// copy of the entry list and compares every result with the oldest prediction
// depends on pst_pkg and the channel interfaces in pst_channels.sv
`timescale 1ns / 100ps

module pst_scoreboard #(
  parameter int DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pst_req_if        req_mon,
  pst_rsp_if        rsp_mon,
  output int        mismatch_count,
  output int        checked_count,
  output int        pending_count,
  output int        peak_fill,
  output int        full_drops,
  output int        fallback_claims
);
  import pst_pkg::*;

  typedef struct {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] claimed;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  // predicted entry list, oldest at slot 0
  logic [HANDLE_W-1:0] tbl_handle [DEPTH];
  logic [SIZE_W-1:0]   tbl_size   [DEPTH];
  logic [MASK_W-1:0]   tbl_mask   [DEPTH];
  int                  tbl_fill;

  reply_t predicted_replies [$];

  function automatic void close_gap(int pos);
    for (int k = pos; k + 1 < tbl_fill; k++) begin
      tbl_handle[k] = tbl_handle[k+1];
      tbl_size[k]   = tbl_size[k+1];
      tbl_mask[k]   = tbl_mask[k+1];
    end
    tbl_fill--;
  endfunction

  function automatic reply_t predict_request(logic [REQ_W-1:0] kind, logic [HANDLE_W-1:0] h,
                                             logic [SIZE_W-1:0] sz, logic [MASK_W-1:0] m);
    reply_t r;
    int     hit;
    r.status  = ST_DONE;
    r.claimed = '0;
    hit       = -1;
    case (kind)
      REQ_RECORD: begin
        if (h == '0) begin
          r.status = ST_NULL;
        end else begin
          for (int k = 0; k < tbl_fill; k++)
            if (hit < 0 && tbl_handle[k] == h) hit = k;
          if (hit >= 0) begin
            // partial update: zero fields keep the stored value
            if (sz != '0) tbl_size[hit] = sz;
            if (m != '0) tbl_mask[hit] = m;
          end else if (tbl_fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            tbl_handle[tbl_fill] = h;
            tbl_size[tbl_fill]   = sz;
            tbl_mask[tbl_fill]   = m;
            tbl_fill++;
          end
        end
      end
      REQ_CLAIM: begin
        // newest equal size wins
        for (int k = tbl_fill - 1; k >= 0; k--)
          if (hit < 0 && tbl_size[k] == sz) hit = k;
        if (hit >= 0) begin
          r.claimed = tbl_handle[hit];
          close_gap(hit);
        end else if (tbl_fill == 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          tbl_fill--;
          r.claimed = tbl_handle[tbl_fill];
          r.status  = ST_FALLBACK;
        end
      end
      REQ_FORGET: begin
        for (int k = 0; k < tbl_fill; k++)
          if (hit < 0 && tbl_handle[k] == h) hit = k;
        if (hit >= 0) close_gap(hit);
        else r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.count = COUNT_W'(tbl_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      tbl_fill = 0;
      predicted_replies.delete();
      mismatch_count  <= 0;
      checked_count   <= 0;
      peak_fill       <= 0;
      full_drops      <= 0;
      fallback_claims <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        want = predict_request(req_mon.req_type, req_mon.image_handle, req_mon.req_size,
                               req_mon.type_mask);
        predicted_replies.push_back(want);
        if (tbl_fill > peak_fill) peak_fill <= tbl_fill;
        if (want.status == ST_FULL) full_drops <= full_drops + 1;
        if (want.status == ST_FALLBACK) fallback_claims <= fallback_claims + 1;
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status  = rsp_mon.status;
        got.claimed = rsp_mon.claimed_handle;
        got.count   = rsp_mon.entry_count;
        checked_count <= checked_count + 1;
        if (predicted_replies.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected result: status %0d handle %h count %0d",
                     $realtime, got.status, got.claimed, got.count);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = predicted_replies.pop_front();
          if (got.status !== want.status || got.claimed !== want.claimed ||
              got.count !== want.count) begin
            if (mismatch_count < 10)
              $display("[%0t] mismatch: status exp %0d got %0d, handle exp %h got %h, count exp %0d got %0d",
                       $realtime, want.status, got.status, want.claimed, got.claimed,
                       want.count, got.count);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    pending_count <= predicted_replies.size();
  end

endmodule

// ----- tb/testbench.sv -----
// top of the pending size match table testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict
// depends on pst_pkg, pst_channels.sv, the block and pst_scoreboard
`timescale 1ns / 100ps

module testbench;
  import pst_pkg::*;

  localparam int DEPTH      = 32;
  localparam int RAND_ITEMS = 600;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 2 * DEPTH + 16;
  localparam int POOL_N     = 40;

  logic clk = 1'b0;
  logic rst_n;

  pst_req_if in_ch ();
  pst_rsp_if out_ch ();

  int mismatch_count, checked_count, pending_count, peak_fill, full_drops, fallback_claims;

  pending_size_match_table #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pst_scoreboard #(.DEPTH(DEPTH)) scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_mon         (in_ch),
    .rsp_mon         (out_ch),
    .mismatch_count  (mismatch_count),
    .checked_count   (checked_count),
    .pending_count   (pending_count),
    .peak_fill       (peak_fill),
    .full_drops      (full_drops),
    .fallback_claims (fallback_claims)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result back-pressure: the style is drawn anew whenever the phase counter wraps
  int stall_style, stall_phase, stall_left, open_left;
  always @(posedge clk) begin
    if (stall_phase == 0) stall_style <= $urandom_range(0, 2);
    stall_phase <= (stall_phase + 1) % 128;
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          out_ch.ready <= 1'b0;
          stall_left   <= stall_left - 1;
        end else if (open_left > 0) begin
          out_ch.ready <= 1'b1;
          open_left    <= open_left - 1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left   <= $urandom_range(1, 20);
          open_left    <= $urandom_range(1, 8);
        end
      end
    endcase
  end

  // watchdog on cycles without any transaction
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int burst_left;
  int sent_count;

  task automatic issue(logic [REQ_W-1:0] kind, logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] sz,
                       logic [MASK_W-1:0] m);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= kind;
    in_ch.image_handle <= h;
    in_ch.req_size     <= sz;
    in_ch.type_mask    <= m;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  logic [HANDLE_W-1:0] handle_pool [POOL_N];
  logic [SIZE_W-1:0]   size_pool   [6];

  initial begin
    int                  roll;
    int                  style;
    logic [REQ_W-1:0]    kind;
    logic [HANDLE_W-1:0] h;
    logic [SIZE_W-1:0]   sz;
    logic [MASK_W-1:0]   m;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_RECORD;
    in_ch.image_handle = '0;
    in_ch.req_size     = '0;
    in_ch.type_mask    = '0;
    out_ch.ready       = 1'b0;
    stall_style = 0;
    stall_phase = 0;
    stall_left  = 0;
    open_left   = 0;
    idle_cycles = 0;
    burst_left  = 0;
    sent_count  = 0;

    for (int i = 0; i < POOL_N; i++)
      handle_pool[i] = (i < 8) ? HANDLE_W'(i + 1) : rand64();
    handle_pool[POOL_N-1] = '1;
    size_pool = '{64'd0, 64'd1, 64'hffff_ffff_ffff_ffff, 64'd0, 64'd0, 64'd0};
    for (int i = 3; i < 6; i++) size_pool[i] = rand64();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    issue(REQ_CLAIM,  '0, 64'd7, '0);                    // claim on empty table
    issue(REQ_FORGET, 64'd5, '0, '0);                    // forget on empty table
    issue(REQ_RECORD, '0, 64'd9, 32'h1);                 // null handle record
    issue(REQ_RSVD,   '1, '1, '1);                       // unused request type
    issue(REQ_RECORD, '1, '1, '1);
    issue(REQ_RECORD, 64'd1, '0, '0);
    issue(REQ_RECORD, 64'd1, 64'd40, '0);                // size-only update
    issue(REQ_RECORD, 64'd1, '0, 32'h8000_0001);         // mask-only update
    issue(REQ_RECORD, 64'h8000_0000_0000_0000, 64'd40, 32'h1);
    issue(REQ_RECORD, 64'd2, '1, 32'hffff_fffe);
    issue(REQ_CLAIM,  '0, 64'd40, '0);                   // newest of two equal sizes
    issue(REQ_CLAIM,  '0, '1, '0);
    issue(REQ_CLAIM,  '0, 64'd12345, '0);                // no equal size, pops newest
    issue(REQ_FORGET, '0, '0, '0);                       // null forget, table not empty
    issue(REQ_RECORD, 64'd3, 64'd0, 32'h5);
    issue(REQ_RECORD, 64'd3, 64'd0, 32'h0);              // already held, nothing nonzero
    issue(REQ_FORGET, 64'd3, '0, '0);
    issue(REQ_FORGET, '1, '0, '0);
    issue(REQ_RECORD, 64'd4, 64'd0, 32'h0);
    issue(REQ_CLAIM,  '0, 64'd0, '0);                    // claim of size zero
    issue(REQ_CLAIM,  '0, 64'd0, '0);

    // random part: phases lean toward filling, draining or a mix
    for (int n = 0; n < RAND_ITEMS; n++) begin
      style = (n / 50) % 3;
      roll  = $urandom_range(0, 99);
      if (roll < 2) kind = REQ_RSVD;
      else if (style == 0) kind = (roll < 80) ? REQ_RECORD : (roll < 90) ? REQ_CLAIM : REQ_FORGET;
      else if (style == 1) kind = (roll < 22) ? REQ_RECORD : (roll < 75) ? REQ_CLAIM : REQ_FORGET;
      else kind = (roll < 45) ? REQ_RECORD : (roll < 72) ? REQ_CLAIM : REQ_FORGET;

      roll = $urandom_range(0, 99);
      if (roll < 5) h = '0;
      else if (roll < ((style == 0) ? 50 : 15)) h = rand64();
      else h = handle_pool[$urandom_range(0, POOL_N - 1)];

      sz = ($urandom_range(0, 4) == 0) ? rand64() : size_pool[$urandom_range(0, 5)];

      roll = $urandom_range(0, 3);
      m = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom();

      issue(kind, h, sz, m);
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests sent, %0d results checked; table peaked at %0d entries",
             sent_count, checked_count, peak_fill);
    $display("%0d records dropped on a full table, %0d claims fell back to the newest entry",
             full_drops, fallback_claims);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
